/* rtl/pts_pkg.sv */
// Shared types, constants and helpers for the permutation test statistics block.
package pts_pkg;

	localparam int ENTRIES  = 1024;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
	localparam logic [16:0] PV_MAX   = 17'd65536;
	localparam logic [43:0] VAR_MAX  = {44{1'b1}};

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ACC  = 2'd1,
		OP_FIN  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [31:0]       coef;
	} item_t;

	typedef struct packed {
		logic [31:0] obs;
		logic [15:0] cnt;
		logic [47:0] sum;
		logic [63:0] sq;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [16:0]      pv;
		logic [31:0]      se;
		logic [31:0]      z;
	} result_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic [47:0] mag48(input logic [47:0] v);
		mag48 = v[47] ? (48'd0 - v) : v;
	endfunction

endpackage

/* rtl/pts_if.sv */
// Valid/ready channel interfaces for item beats and result beats.
interface pts_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [pts_pkg::IDX_W-1:0] entry_index;
	logic [31:0]               coef_value;

	modport source (output valid, output opcode, output entry_index, output coef_value,
		input ready);
	modport sink (input valid, input opcode, input entry_index, input coef_value,
		output ready);
endinterface

interface pts_out_if;
	logic                      valid;
	logic                      ready;
	logic [pts_pkg::IDX_W-1:0] out_index;
	logic [16:0]               p_value;
	logic [31:0]               std_error;
	logic [31:0]               z_score;

	modport source (output valid, output out_index, output p_value, output std_error,
		output z_score, input ready);
	modport sink (input valid, input out_index, input p_value, input std_error,
		input z_score, output ready);
endinterface

/* rtl/pts_front.sv */
// Front end: accepts item beats, drops unused opcodes, queues the rest.
module pts_front (
	input  logic           clk,
	input  logic           arst_n,
	pts_in_if.sink         item_in,
	output pts_pkg::qhead_t head,
	input  logic           pop
);

	pts_pkg::item_t fifo_q [pts_pkg::Q_DEPTH];
	logic [pts_pkg::Q_PTR_W-1:0] wp_q, rp_q;
	logic [pts_pkg::Q_CNT_W-1:0] count_q;
	logic push, do_pop;

	assign item_in.ready = count_q != pts_pkg::Q_CNT_W'(pts_pkg::Q_DEPTH);
	assign push = item_in.valid && item_in.ready &&
		(pts_pkg::op_t'(item_in.opcode) != pts_pkg::OP_NONE);
	assign do_pop = pop && (count_q != '0);
	assign head.valid = count_q != '0;
	assign head.item = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{op: pts_pkg::op_t'(item_in.opcode),
				idx: item_in.entry_index, coef: item_in.coef_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (!push && do_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/pts_div.sv */
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
module pts_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quot
);

	logic [31:0] rem_q, dvs_q;
	logic [63:0] quot_q;
	logic [5:0]  cnt_q;
	logic        run_q, done_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quot_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign done  = done_q;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvs_q  <= divisor;
				quot_q <= dividend;
			end else if (run_q) begin
				rem_q  <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
				quot_q <= {quot_q[62:0], fits};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/pts_sqrt.sv */
// Integer square root, two radicand bits per cycle.
module pts_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] x_q, res_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        run_q, done_q;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				x_q   <= radicand;
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end else if (run_q) begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/pts_back.sv */
// Back end: per-entry state memory, accumulate update and finalize sequencer.
module pts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     perm_count,
	input  pts_pkg::qhead_t head,
	output logic            pop,
	pts_out_if.source       result_out
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_ACCW, ST_PV, ST_MM, ST_MSQ, ST_M2, ST_VAR, ST_SQ, ST_Z, ST_OUT
	} state_t;

	state_t state_q;
	pts_pkg::entry_t mem [pts_pkg::ENTRIES];
	pts_pkg::entry_t rd_q, ent_q, wd;
	pts_pkg::item_t  cur_q;
	pts_pkg::result_t res_q;
	logic [pts_pkg::IDX_W-1:0] wa;
	logic        we, re, go_q, ovalid_q;
	logic [15:0] n_q;
	logic [63:0] sqm_q, msq_q, dvd;
	logic [31:0] dvs, mm_q, se_q, z_q, cmag, omag;
	logic        neg_q, dneg_q;
	logic [16:0] pv_q;
	logic [43:0] m2_q, var_q;
	logic [33:0] dmag_q;
	logic        dstart, ddone, sstart, sdone;
	logic [63:0] quot, prod, msq_diff;
	logic [31:0] root;
	logic [47:0] smag;
	logic signed [33:0] diff;

	assign cmag = pts_pkg::mag32(cur_q.coef);
	assign omag = pts_pkg::mag32(rd_q.obs);
	assign smag = pts_pkg::mag48(ent_q.sum);
	assign prod = 64'(mm_q) * 64'(mm_q);
	assign msq_diff = msq_q - 64'(m2_q);
	assign diff = 34'(signed'(ent_q.obs)) -
		(neg_q ? -34'(signed'({1'b0, mm_q})) : 34'(signed'({1'b0, mm_q})));

	pts_div u_div (.clk, .arst_n, .start(dstart), .dividend(dvd), .divisor(dvs),
		.done(ddone), .quot);
	pts_sqrt u_sqrt (.clk, .arst_n, .start(sstart), .radicand({var_q, 20'd0}),
		.done(sdone), .root);

	always_comb begin
		pop = 1'b0;
		re  = 1'b0;
		we  = 1'b0;
		wa  = cur_q.idx;
		wd  = ent_q;
		if (state_q == ST_IDLE && head.valid) begin
			pop = 1'b1;
			re  = 1'b1;
			if (head.item.op == pts_pkg::OP_LOAD) begin
				we = 1'b1;
				wa = head.item.idx;
				wd = '{obs: head.item.coef, cnt: '0, sum: '0, sq: '0};
			end
		end else if (state_q == ST_ACCW) begin
			we = 1'b1;
			wd.sq = ent_q.sq + {20'd0, sqm_q[63:20]};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[head.item.idx];
	end

	always_comb begin
		dvd = {16'd0, smag};
		dvs = {16'd0, n_q};
		case (state_q)
			ST_PV: begin
				dvd = {31'd0, (33'(ent_q.cnt) + 33'd1) << 16};
				dvs = 32'(n_q) + 32'd1;
			end
			ST_MSQ: dvd = ent_q.sq;
			ST_Z: begin
				dvd = {14'd0, dmag_q, 16'd0};
				dvs = se_q;
			end
			default: ;
		endcase
		dstart = !go_q && (state_q == ST_PV || state_q == ST_MM || state_q == ST_MSQ ||
			(state_q == ST_Z && se_q != '0));
		sstart = !go_q && state_q == ST_SQ;
	end

	assign result_out.valid     = ovalid_q;
	assign result_out.out_index = res_q.idx;
	assign result_out.p_value   = res_q.pv;
	assign result_out.std_error = res_q.se;
	assign result_out.z_score   = res_q.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			go_q     <= 1'b0;
			ovalid_q <= 1'b0;
			cur_q    <= '0;
			ent_q    <= '0;
			n_q      <= 16'd1;
			sqm_q    <= '0;
			msq_q    <= '0;
			mm_q     <= '0;
			neg_q    <= 1'b0;
			pv_q     <= '0;
			m2_q     <= '0;
			var_q    <= '0;
			se_q     <= '0;
			z_q      <= '0;
			dmag_q   <= '0;
			dneg_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			if (result_out.ready && state_q != ST_OUT) ovalid_q <= 1'b0;
			if (dstart || sstart) go_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						cur_q <= head.item;
						n_q   <= (perm_count == '0) ? 16'd1 : perm_count;
						if (head.item.op != pts_pkg::OP_LOAD) state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (cur_q.op == pts_pkg::OP_ACC) begin
						sqm_q <= 64'(cmag) * 64'(cmag);
						ent_q <= '{obs: rd_q.obs,
							cnt: (cmag >= omag && rd_q.cnt != 16'hFFFF) ?
								rd_q.cnt + 16'd1 : rd_q.cnt,
							sum: rd_q.sum + 48'(signed'(cur_q.coef)),
							sq: rd_q.sq};
						state_q <= ST_ACCW;
					end else begin
						ent_q   <= rd_q;
						state_q <= ST_PV;
					end
				end
				ST_ACCW: state_q <= ST_IDLE;
				ST_PV: if (ddone) begin
					go_q    <= 1'b0;
					pv_q    <= (quot > 64'(pts_pkg::PV_MAX)) ? pts_pkg::PV_MAX : quot[16:0];
					state_q <= ST_MM;
				end
				ST_MM: if (ddone) begin
					go_q  <= 1'b0;
					neg_q <= ent_q.sum[47];
					if (ent_q.sum[47])
						mm_q <= (quot > 64'h8000_0000) ? 32'h8000_0000 : quot[31:0];
					else
						mm_q <= (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
					state_q <= ST_MSQ;
				end
				ST_MSQ: if (ddone) begin
					go_q    <= 1'b0;
					msq_q   <= quot;
					state_q <= ST_M2;
				end
				ST_M2: begin
					m2_q    <= prod[63:20];
					state_q <= ST_VAR;
				end
				ST_VAR: begin
					if (msq_q <= 64'(m2_q)) var_q <= '0;
					else if (msq_diff > 64'(pts_pkg::VAR_MAX)) var_q <= pts_pkg::VAR_MAX;
					else var_q <= msq_diff[43:0];
					dneg_q  <= diff[33];
					dmag_q  <= diff[33] ? 34'(-diff) : 34'(diff);
					state_q <= ST_SQ;
				end
				ST_SQ: if (sdone) begin
					go_q    <= 1'b0;
					se_q    <= root;
					state_q <= ST_Z;
				end
				ST_Z: begin
					if (se_q == '0) begin
						z_q     <= '0;
						state_q <= ST_OUT;
					end else if (ddone) begin
						go_q <= 1'b0;
						if (dneg_q)
							z_q <= 32'd0 - ((quot > 64'h8000_0000) ? 32'h8000_0000 :
								quot[31:0]);
						else
							z_q <= (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || result_out.ready) begin
						ovalid_q <= 1'b1;
						res_q    <= '{idx: cur_q.idx, pv: pv_q, se: se_q, z: z_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/permutation_test_stats.sv */
// Top level of the permutation test statistics block.
// item_in carries beats of {opcode, entry_index, coef_value}: load stores the
// observed coefficient and clears the entry, accumulate adds one permuted
// coefficient, finalize reports p-value, standard error and z-score on
// result_out. Opcode three is taken and dropped.
// A four-beat queue parts the front end from the back end, so item_in keeps
// taking beats while the back end works or result_out is stalled.
// The back end writes a load as it is popped; an accumulate reads, squares
// and writes back through the state memory; finalize runs three 64-step
// divides, a 32-step root and a final divide on the shared bit-serial
// divider. Results come out in item order. The user must write perm_count
// via cfg_we/cfg_wdata only while idle; the block does not enforce it; reset
// sets 1. Reset empties the queue and drops any pending result; entry state
// is undefined until a load writes it. When result_out.ready is low the
// result holds, the back end waits and the queue fills before item_in stalls.
module permutation_test_stats (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	pts_in_if.sink      item_in,
	pts_out_if.source   result_out
);

	logic [15:0]     perm_count_q;
	pts_pkg::qhead_t head;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) perm_count_q <= 16'd1;
		else if (cfg_we) perm_count_q <= cfg_wdata;
	end

	pts_front u_front (.clk, .arst_n, .item_in, .head, .pop);
	pts_back u_back (.clk, .arst_n, .perm_count(perm_count_q), .head, .pop, .result_out);

	a_pv_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> result_out.p_value <= pts_pkg::PV_MAX)
		else $error("p-value above one");

	a_z_zero_se: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.std_error == '0) |-> result_out.z_score == '0)
		else $error("non-zero z-score with zero standard error");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

endmodule
